// ----- src/smaf_pkg.sv -----
// smaf_pkg: types, constants and helpers shared by the smooth axis motion follower.
// No dependencies; every other file refers to it by scoped names.
package smaf_pkg;

    localparam int AXES      = 4;
    localparam int COORD_W   = 24;
    localparam int ACCEL_W   = 16;
    localparam int CFG_IDX_W = 4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [ACCEL_W-1:0]        accel_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    // Register indexes of the configuration port
    localparam cfg_idx_t REG_ACCEL_X    = 4'd0;
    localparam cfg_idx_t REG_ACCEL_Y    = 4'd1;
    localparam cfg_idx_t REG_ACCEL_Z    = 4'd2;
    localparam cfg_idx_t REG_ACCEL_TILT = 4'd3;

    localparam coord_t COORD_MAX = 24'sh7FFFFF;
    localparam coord_t COORD_MIN = 24'sh800000;

    // Reset values per axis: acceleration in Q8 counts, position in whole units
    localparam accel_t ACCEL_RESET [0:7] = '{
        16'd26, 16'd26, 16'd26, 16'd38, 16'd26, 16'd26, 16'd26, 16'd26
    };
    localparam int POS_RESET_WHOLE [0:7] = '{0, 100, 0, 90, 0, 0, 0, 0};

    typedef struct packed {
        coord_t target_x;
        coord_t target_y;
        coord_t target_z;
        coord_t target_tilt;
    } in_item_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        coord_t pos_tilt;
        logic   all_arrived;
    } out_item_t;

    // What one lane reports to the merge stage
    typedef struct packed {
        coord_t pos;
        logic   arrived;
    } lane_res_t;

    // Clamp a 26-bit signed sum to the 24-bit coordinate range
    function automatic coord_t sat_coord(input logic signed [25:0] x);
        coord_t r;
        if ((x[25:23] == 3'b000) || (x[25:23] == 3'b111)) begin
            r = x[23:0];
        end else if (x[25]) begin
            r = COORD_MIN;
        end else begin
            r = COORD_MAX;
        end
        return r;
    endfunction

endpackage

// ----- src/smaf_lane.sv -----
// smaf_lane: one axis of the follower; holds position, velocity and acceleration
// and computes the next tick's state. Depends on smaf_pkg.
module smaf_lane #(
    parameter logic signed [23:0] POS_INIT   = 24'sd0,
    parameter logic [15:0]        ACCEL_INIT = 16'd26
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic               cfg_we,
    input  smaf_pkg::accel_t   cfg_data,
    input  smaf_pkg::coord_t   target,
    output smaf_pkg::lane_res_t res
);

    smaf_pkg::coord_t pos_reg, pos_next;
    smaf_pkg::coord_t vel_reg, vel_next;
    smaf_pkg::accel_t accel_reg;

    logic signed [24:0] diff;
    logic [24:0]        gap_abs;
    logic               diff_pos, diff_neg, diff_zero, opposite;
    smaf_pkg::coord_t   vz;
    logic [23:0]        vabs;
    logic [47:0]        vsq;
    logic [41:0]        brake;
    logic               stopping, speed_up;
    logic signed [25:0] vstep;
    smaf_pkg::coord_t   v1;
    logic signed [25:0] pv;
    logic signed [26:0] rem;
    logic               snap;

    always_comb begin
        diff      = $signed({target[23], target}) - $signed({pos_reg[23], pos_reg});
        diff_zero = (diff == 25'sd0);
        diff_neg  = diff[24];
        diff_pos  = !diff_neg && !diff_zero;
        gap_abs   = diff_neg ? 25'(-diff) : 25'(diff);

        // velocity pointing away from the target is dropped first
        opposite = (diff_pos && vel_reg[23]) ||
                   (diff_neg && !vel_reg[23] && (vel_reg != 24'sd0));
        vz       = opposite ? 24'sd0 : vel_reg;
        vabs     = vz[23] ? 24'(-vz) : 24'(vz);

        // stopping distance test: v*v >= 2*a*|d-p|
        vsq      = vabs * vabs;
        brake    = {accel_reg, 1'b0} * gap_abs;
        stopping = (vsq >= {6'd0, brake});

        speed_up = diff_pos ^ stopping;
        if (speed_up) begin
            vstep = $signed({{2{vz[23]}}, vz}) + $signed({10'd0, accel_reg});
        end else begin
            vstep = $signed({{2{vz[23]}}, vz}) - $signed({10'd0, accel_reg});
        end
        v1 = diff_zero ? vel_reg : smaf_pkg::sat_coord(vstep);

        // snap when this step reaches or crosses the target
        pv   = $signed({{2{pos_reg[23]}}, pos_reg}) + $signed({{2{v1[23]}}, v1});
        rem  = $signed({{3{target[23]}}, target}) - $signed({pv[25], pv});
        snap = diff_zero || (rem == 27'sd0) || (diff[24] != rem[26]);

        pos_next = snap ? target : smaf_pkg::sat_coord(pv);
        vel_next = snap ? 24'sd0 : v1;

        res.pos     = pos_next;
        res.arrived = (pos_next == target);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_INIT;
            vel_reg   <= 24'sd0;
            accel_reg <= ACCEL_INIT;
        end else begin
            if (step) begin
                pos_reg <= pos_next;
                vel_reg <= vel_next;
            end
            if (cfg_we) begin
                accel_reg <= cfg_data;
            end
        end
    end

endmodule

// ----- src/smaf_merge.sv -----
// smaf_merge: joins the lane results into one result item and buffers it in an
// output register backed by a skid register. Depends on smaf_pkg.
module smaf_merge (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  smaf_pkg::lane_res_t  lanes [smaf_pkg::AXES],
    output logic                 m_valid,
    input  logic                 m_ready,
    output smaf_pkg::out_item_t  m_data
);

    smaf_pkg::out_item_t merged;
    smaf_pkg::out_item_t out_reg, skid_reg;
    logic                out_valid_reg, skid_valid_reg;
    logic                in_acc, pop;

    always_comb begin
        merged.pos_x       = lanes[0].pos;
        merged.pos_y       = lanes[1].pos;
        merged.pos_z       = lanes[2].pos;
        merged.pos_tilt    = lanes[3].pos;
        merged.all_arrived = 1'b1;
        for (int i = 0; i < smaf_pkg::AXES; i++) begin
            merged.all_arrived = merged.all_arrived & lanes[i].arrived;
        end
    end

    assign s_ready = !skid_valid_reg;
    assign in_acc  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else if (!in_acc) begin
                out_valid_reg <= 1'b0;
            end
        end else if (in_acc) begin
            if (!out_valid_reg) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // payload moves alongside the valid bits above
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (in_acc) begin
                out_reg <= merged;
            end
        end else if (in_acc) begin
            if (!out_valid_reg) begin
                out_reg <= merged;
            end else begin
                skid_reg <= merged;
            end
        end
    end

endmodule

// ----- src/smooth_axis_motion_follower_top.sv -----
// smooth_axis_motion_follower_top: four axis lanes side by side plus a merge stage.
// Depends on smaf_pkg, smaf_lane and smaf_merge.
//
//   channel   ports                               carries
//   input     s_valid  s_ready  s_data            targets x, y, z, tilt
//   result    m_valid  m_ready  m_data            positions and all_arrived
//   config    cfg_valid cfg_ready cfg_index cfg_data   per-axis acceleration
//
// One item per cycle while s_ready is high; results are registered at the output.
// Every lane finishes its whole axis update in the accepting cycle, since the
// next tick needs the position and velocity this one leaves behind.
// Reset (aresetn low, synchronous) restores positions, velocities and accels.
// A two-entry output buffer keeps s_ready high through one stalled result.
module smooth_axis_motion_follower_top #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  smaf_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output smaf_pkg::out_item_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  smaf_pkg::cfg_idx_t   cfg_index,
    input  smaf_pkg::accel_t     cfg_data
);

    smaf_pkg::coord_t    targets [smaf_pkg::AXES];
    smaf_pkg::lane_res_t lanes   [smaf_pkg::AXES];
    logic                step;

    assign cfg_ready = 1'b1;
    assign step      = s_valid && s_ready;

    assign targets[0] = s_data.target_x;
    assign targets[1] = s_data.target_y;
    assign targets[2] = s_data.target_z;
    assign targets[3] = s_data.target_tilt;

    for (genvar i = 0; i < smaf_pkg::AXES; i++) begin : g_lane
        localparam logic signed [23:0] POS_INIT =
            24'(smaf_pkg::POS_RESET_WHOLE[i] * (1 << FRAC_BITS));
        logic cfg_we;

        assign cfg_we = cfg_valid && cfg_ready &&
                        (cfg_index == smaf_pkg::CFG_IDX_W'(i));

        smaf_lane #(
            .POS_INIT   (POS_INIT),
            .ACCEL_INIT (smaf_pkg::ACCEL_RESET[i])
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .step     (step),
            .cfg_we   (cfg_we),
            .cfg_data (cfg_data),
            .target   (targets[i]),
            .res      (lanes[i])
        );
    end

    smaf_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .lanes   (lanes),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- src/smaf_checker.sv -----
// smaf_checker: port-level assertions for the motion follower, bound to the top.
// Depends on smaf_pkg and smooth_axis_motion_follower_top.
module smaf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input smaf_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input smaf_pkg::out_item_t m_data,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input smaf_pkg::cfg_idx_t  cfg_index,
    input smaf_pkg::accel_t    cfg_data
);

    // a held result stays offered until its transfer
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before transfer");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data))
        else $error("result changed while stalled");

    // input backpressure only when the output side is full
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    // a transfer into an empty block is offered on the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> m_valid)
        else $error("result missing after input transfer");

endmodule

bind smooth_axis_motion_follower_top smaf_checker u_smaf_checker (.*);
